@@ src/bsd_pkg.sv @@
// ----------------------------------------------------------------------------
// bsd_pkg: shared definitions for the broadcast storm detector
// Field widths, action and register codes, per-port state layout and the
// state machine encodings used by the sequencer and the rate divider.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int PORTS_DEFAULT = 4;

    localparam int PORT_W  = 2;
    localparam int CNT_W   = 32;
    localparam int RATE_W  = 32;
    // delta * 100 needs seven bits above the 32-bit delta.
    localparam int NUM_W   = CNT_W + 7;
    localparam int ACT_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [RATE_W-1:0] RATE_MAX        = '1;
    localparam logic [CNT_W-1:0]  THRESHOLD_RESET = 32'd1000;

    // Hysteresis limits: a counter strictly above the limit triggers.
    localparam logic [2:0] OVER_LIMIT  = 3'd3;
    localparam logic [2:0] UNDER_LIMIT = 3'd3;
    localparam logic [1:0] QUIET_LIMIT = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SHUT    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LIMIT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UNLIMIT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ALARM   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b1;

    typedef struct packed {
        logic [PORT_W-1:0] port_index;
        logic              port_up;
        logic [CNT_W-1:0]  rx_bcast_count;
        logic [CNT_W-1:0]  tx_bcast_count;
        logic [CNT_W-1:0]  now_tick;
    } sample_t;

    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic [ACT_W-1:0]  action;
        logic [RATE_W-1:0] rx_rate;
        logic [RATE_W-1:0] tx_rate;
    } result_t;

    typedef struct packed {
        logic [2:0] over_cnt;
        logic [2:0] under_cnt;
        logic [1:0] quiet_cnt;
        logic       quiet_armed;
        logic       limited;
    } storm_flags_t;

    typedef struct packed {
        logic [CNT_W-1:0] last_rx;
        logic [CNT_W-1:0] last_tx;
        logic [CNT_W-1:0] last_tick;
        storm_flags_t     flags;
    } port_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_RX_GO,
        SEQ_RX_WAIT,
        SEQ_TX_GO,
        SEQ_TX_WAIT,
        SEQ_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_CHECK,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

@@ src/bsd_channels_if.sv @@
// ----------------------------------------------------------------------------
// bsd channels: valid/ready streams for samples and results
// One interface per direction, each carrying a packed payload struct.
// ----------------------------------------------------------------------------
interface bsd_sample_if;
    import bsd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bsd_result_if;
    import bsd_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/broadcast_storm_detector.sv @@
// ----------------------------------------------------------------------------
// broadcast_storm_detector: per-port broadcast storm detection
// Turns poll samples of broadcast counters into rates and runs the storm
// hysteresis of each port, giving one result item per sample item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake    Carries
//  --------  ---------  -----------  ------------------------------------------
//  sample    in         valid/ready  port, up flag, rx/tx counters, tick
//  result    out        valid/ready  port, action, rx and tx rates
//  cfg       in         write only   threshold (index 0), shutdown mode (1)
//
// A sample for a port that is up passes, from its acceptance to the earliest
// acceptance of the next item, through the state read, two passes of the
// shared divider (start, check step, 32 quotient bits, done), the closing
// write and the idle state in which the block is ready. A pass whose
// quotient saturates, or whose interval is zero, ends after its check step.
// A port that is down, or beyond the configured port count, skips both
// divider passes.
// Reset loads the register defaults and clears the sequencer and the per-port
// valid bits, so every port starts with zero history. The result sits in an
// output register, so a stalled result holds only the closing step; the next
// sample is still accepted while the result waits.
//
module broadcast_storm_detector #(
    parameter int PORTS = bsd_pkg::PORTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    bsd_sample_if.sink                      sample,
    bsd_result_if.source                    result
);
    import bsd_pkg::*;

    localparam int ADDR_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // Configuration registers.
    logic [CNT_W-1:0] threshold_reg;
    logic             mode_reg;

    // Sequencer state and the captured sample.
    seq_state_t       state_reg, state_next;
    sample_t          sample_reg;
    logic             in_range_reg;
    logic [CNT_W-1:0] rx_delta_reg;
    logic [CNT_W-1:0] tx_delta_reg;
    logic [CNT_W-1:0] interval_reg;
    logic [RATE_W-1:0] rx_rate_reg;
    logic [RATE_W-1:0] tx_rate_reg;

    // Output register.
    result_t result_reg;
    logic    out_valid_reg;

    // Internal connections.
    logic              accept;
    logic              slot_free;
    logic              out_load;
    logic              mem_wr_en;
    port_state_t       row_cur;
    port_state_t       row_new;
    logic              div_start;
    logic [CNT_W-1:0]  div_delta;
    logic              div_done;
    logic [RATE_W-1:0] div_quotient;
    storm_flags_t      flags_next;
    logic [ACT_W-1:0]  hyst_action;
    logic              port_active;

    assign accept      = sample.valid && sample.ready;
    assign slot_free   = !out_valid_reg || result.ready;
    assign port_active = in_range_reg && sample_reg.port_up;

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            mode_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_MODE:      mode_reg      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-port state store and the shared divider.
    // ------------------------------------------------------------------
    bsd_state_mem #(
        .DEPTH  (PORTS),
        .ADDR_W (ADDR_W)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(sample.payload.port_index)),
        .rd_data (row_cur),
        .wr_en   (mem_wr_en),
        .wr_addr (ADDR_W'(sample_reg.port_index)),
        .wr_data (row_new)
    );

    bsd_rate_div u_rate_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .delta    (div_delta),
        .divisor  (interval_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    bsd_hysteresis u_hysteresis (
        .flags_cur     (row_cur.flags),
        .rx_rate       (rx_rate_reg),
        .threshold     (threshold_reg),
        .shutdown_mode (mode_reg),
        .flags_next    (flags_next),
        .action        (hyst_action)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SEQ_READ;
                end
            end
            SEQ_READ:
            begin
                state_next = port_active ? SEQ_RX_GO : SEQ_FINISH;
            end
            SEQ_RX_GO:
            begin
                state_next = SEQ_RX_WAIT;
            end
            SEQ_RX_WAIT:
            begin
                if (div_done)
                begin
                    state_next = SEQ_TX_GO;
                end
            end
            SEQ_TX_GO:
            begin
                state_next = SEQ_TX_WAIT;
            end
            SEQ_TX_WAIT:
            begin
                if (div_done)
                begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample.ready = (state_reg == SEQ_IDLE);
        div_start    = (state_reg == SEQ_RX_GO) || (state_reg == SEQ_TX_GO);
        div_delta    = (state_reg == SEQ_RX_GO) ? rx_delta_reg : tx_delta_reg;
        out_load     = (state_reg == SEQ_FINISH) && slot_free;
        // A port beyond the port count leaves the store untouched.
        mem_wr_en    = out_load && in_range_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Sample capture, deltas and rates.
    // ------------------------------------------------------------------
    // A counter that went backwards has wrapped: the delta is then
    // cur - prev - 1, which is cur + ~prev. The tick interval wraps the same
    // way, but equal ticks count as a full wrap too.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg   <= sample.payload;
            in_range_reg <= (int'(sample.payload.port_index) < PORTS);
        end
        if (state_reg == SEQ_READ)
        begin
            rx_delta_reg <= sample_reg.rx_bcast_count + ~row_cur.last_rx
                + {{(CNT_W-1){1'b0}}, (sample_reg.rx_bcast_count >= row_cur.last_rx)};
            tx_delta_reg <= sample_reg.tx_bcast_count + ~row_cur.last_tx
                + {{(CNT_W-1){1'b0}}, (sample_reg.tx_bcast_count >= row_cur.last_tx)};
            interval_reg <= sample_reg.now_tick + ~row_cur.last_tick
                + {{(CNT_W-1){1'b0}}, (sample_reg.now_tick > row_cur.last_tick)};
        end
        if ((state_reg == SEQ_RX_WAIT) && div_done)
        begin
            rx_rate_reg <= div_quotient;
        end
        if ((state_reg == SEQ_TX_WAIT) && div_done)
        begin
            tx_rate_reg <= div_quotient;
        end
    end

    // ------------------------------------------------------------------
    // Closing step: new row for the store and the result item.
    // ------------------------------------------------------------------
    // A port that is down loses its history but keeps its storm flags.
    always_comb
    begin
        if (sample_reg.port_up)
        begin
            row_new.last_rx   = sample_reg.rx_bcast_count;
            row_new.last_tx   = sample_reg.tx_bcast_count;
            row_new.last_tick = sample_reg.now_tick;
            row_new.flags     = flags_next;
        end
        else
        begin
            row_new.last_rx   = '0;
            row_new.last_tx   = '0;
            row_new.last_tick = '0;
            row_new.flags     = row_cur.flags;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg.out_port <= sample_reg.port_index;
            result_reg.action   <= port_active ? hyst_action : ACT_NONE;
            result_reg.rx_rate  <= port_active ? rx_rate_reg : '0;
            result_reg.tx_rate  <= port_active ? tx_rate_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = result_reg;

endmodule

@@ src/bsd_state_mem.sv @@
// ----------------------------------------------------------------------------
// bsd_state_mem: per-port state store
// One row per port with registered read data. A valid bit per row, cleared
// by reset, makes an unwritten row read as all zeros.
// ----------------------------------------------------------------------------
module bsd_state_mem #(
    parameter int DEPTH  = bsd_pkg::PORTS_DEFAULT,
    parameter int ADDR_W = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output bsd_pkg::port_state_t  rd_data,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  bsd_pkg::port_state_t  wr_data
);
    import bsd_pkg::*;

    port_state_t mem [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    port_state_t rd_q_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

@@ src/bsd_rate_div.sv @@
// ----------------------------------------------------------------------------
// bsd_rate_div: iterative rate divider
// Computes floor(delta * 100 / interval), saturated to 32 bits, one
// quotient bit per cycle through a single shared subtractor.
// ----------------------------------------------------------------------------
module bsd_rate_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bsd_pkg::CNT_W-1:0]  delta,
    input  logic [bsd_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [bsd_pkg::RATE_W-1:0] quotient
);
    import bsd_pkg::*;

    localparam int HI_W = NUM_W - RATE_W;

    div_state_t state_reg, state_next;

    logic [NUM_W-1:0]  num_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [RATE_W-1:0] quo_reg;
    logic [4:0]        cnt_reg;

    logic [NUM_W-1:0]  scaled;
    logic [CNT_W:0]    op_a;
    logic [CNT_W+1:0]  diff;
    logic              ge;
    logic              den_zero;
    logic              sat;

    // delta * 100 = delta * 64 + delta * 32 + delta * 4
    assign scaled = {1'b0, delta, 6'b0} + {2'b0, delta, 5'b0} + {5'b0, delta, 2'b0};

    // The shared compare/subtract unit. In the check step it tests whether
    // the upper bits of the dividend already reach the divisor, which means
    // the quotient does not fit in 32 bits.
    always_comb
    begin
        if (state_reg == DIV_CHECK)
        begin
            op_a = {{(CNT_W + 1 - HI_W){1'b0}}, num_reg[NUM_W-1:RATE_W]};
        end
        else
        begin
            op_a = {rem_reg, quo_reg[RATE_W-1]};
        end
        diff = {1'b0, op_a} - {2'b0, den_reg};
        ge   = !diff[CNT_W+1];
    end

    assign den_zero = (den_reg == '0);
    assign sat      = den_zero ? (num_reg != '0) : ge;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_CHECK;
                end
            end
            DIV_CHECK:
            begin
                if (den_zero || ge)
                begin
                    state_next = DIV_DONE;
                end
                else
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done = (state_reg == DIV_DONE);
    end

    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    num_reg <= scaled;
                    den_reg <= divisor;
                end
            end
            DIV_CHECK:
            begin
                rem_reg <= {{(CNT_W - HI_W){1'b0}}, num_reg[NUM_W-1:RATE_W]};
                cnt_reg <= 5'd31;
                if (den_zero || ge)
                begin
                    quo_reg <= sat ? RATE_MAX : '0;
                end
                else
                begin
                    quo_reg <= num_reg[RATE_W-1:0];
                end
            end
            DIV_RUN:
            begin
                rem_reg <= ge ? diff[CNT_W-1:0] : op_a[CNT_W-1:0];
                quo_reg <= {quo_reg[RATE_W-2:0], ge};
                cnt_reg <= cnt_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ src/bsd_hysteresis.sv @@
// ----------------------------------------------------------------------------
// bsd_hysteresis: storm hysteresis for one port
// Given the stored flags of a port and its new receive rate, produces the
// updated flags and the action for this sample.
// ----------------------------------------------------------------------------
module bsd_hysteresis (
    input  bsd_pkg::storm_flags_t       flags_cur,
    input  logic [bsd_pkg::RATE_W-1:0]  rx_rate,
    input  logic [bsd_pkg::CNT_W-1:0]   threshold,
    input  logic                        shutdown_mode,
    output bsd_pkg::storm_flags_t       flags_next,
    output logic [bsd_pkg::ACT_W-1:0]   action
);
    import bsd_pkg::*;

    always_comb
    begin
        storm_flags_t f;
        logic [ACT_W-1:0] act;

        f   = flags_cur;
        act = ACT_NONE;

        if (rx_rate > threshold)
        begin
            f.over_cnt  = f.over_cnt + 3'd1;
            f.under_cnt = '0;
            f.quiet_cnt = '0;
        end
        else
        begin
            f.over_cnt = '0;
            if (!f.quiet_armed)
            begin
                f.quiet_cnt = '0;
            end
            else
            begin
                f.quiet_cnt = f.quiet_cnt + 2'd1;
            end
            if (f.limited)
            begin
                f.under_cnt = f.under_cnt + 3'd1;
                if (f.under_cnt > UNDER_LIMIT)
                begin
                    act           = ACT_UNLIMIT;
                    f.quiet_armed = 1'b1;
                    f.quiet_cnt   = '0;
                    f.limited     = 1'b0;
                end
            end
        end

        // A storm in shutdown mode repeats the shut action on every fourth
        // sample; in limit mode the limit is applied only once.
        if (f.over_cnt > OVER_LIMIT)
        begin
            if (shutdown_mode)
            begin
                act = ACT_SHUT;
            end
            else if (!f.limited)
            begin
                act       = ACT_LIMIT;
                f.limited = 1'b1;
            end
            f.over_cnt = '0;
        end

        if (f.quiet_cnt > QUIET_LIMIT)
        begin
            act           = ACT_ALARM;
            f.quiet_armed = 1'b0;
            f.quiet_cnt   = '0;
        end

        flags_next = f;
        action     = act;
    end

endmodule

@@ dv/broadcast_storm_detector_test.sv @@
// ----------------------------------------------------------------------------
// broadcast_storm_detector_test: self-checking bench for the storm detector
// Drives poll samples through the sample channel, predicts every result item
// with a behavioural copy of the per-port rate and hysteresis logic, and
// compares each accepted result field by field. A short table of directed
// samples comes first, then random traffic under several register settings
// and several patterns of idling on both channels.
// ----------------------------------------------------------------------------
module broadcast_storm_detector_test;
    import bsd_pkg::*;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // This much slack after the last result covers any trailing activity
    // of a sample for a port that is up.
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 155;
    localparam int HOLD_CYCLES   = 500;
    localparam int PLAN_ROWS     = 22;

    typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    // One row of the directed table. Configuration rows use reg_index and
    // reg_value; sample rows use smp, and want when typed is set.
    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [CFG_DATA_W-1:0]    reg_value;
        sample_t                  smp;
        logic                     typed;
        result_t                  want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bsd_sample_if sample_ch ();
    bsd_result_if result_ch ();

    broadcast_storm_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #5 clk = ~clk;

    // Mirror of the block's registers and per-port state.
    logic [31:0] storm_thresh;
    logic        shut_on_storm;
    logic [31:0] seen_rx [4];
    logic [31:0] seen_tx [4];
    logic [31:0] seen_tick [4];
    logic [2:0]  over_run [4];
    logic [2:0]  under_run [4];
    logic [1:0]  quiet_run [4];
    logic        quiet_pending [4];
    logic        rate_limited [4];

    // Results still owed by the block, oldest first.
    result_t pending_results [$];
    int      errors = 0;
    int      cycle_count = 0;

    // Idling controls. The sender's figure is only read by the stimulus
    // process; the receiver's is updated with nonblocking assignments.
    int tx_idle_pct = 16;
    int rx_idle_pct = 87;

    // A long hold-off is requested by bumping hold_asked; the receiver
    // process counts the stall itself.
    int hold_asked = 0;
    int hold_given = 0;
    int hold_left  = 0;

    // Per-port run of well-formed samples: a storm run or a quiet run.
    int run_left [4] = '{0, 0, 0, 0};
    bit run_storm [4];

    // Directed table. Expected values are written out only where they can be
    // seen directly: the first sample after reset, the counter and tick
    // extremes, a zero tick interval and a port that goes down. The storm
    // sequence on port 2 walks limit, removal and the storm-stopped alarm;
    // the rows on port 0 after the mode change walk a shutdown.
    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{0, 1, 0, 0, 0}, 1, '{0, ACT_NONE, 0, 0}},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{1, 1, MAX32, MAX32, MAX32}, 1,
          '{1, ACT_NONE, 100, 100}},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{1, 1, 5, 0, 0}, 1, '{1, ACT_NONE, MAX32, 0}},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{1, 1, MAX32, 0, 1}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{3, 0, MAX32, MAX32, MAX32}, 1,
          '{3, ACT_NONE, 0, 0}},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{3, 1, 0, 0, 0}, 1, '{3, ACT_NONE, 0, 0}},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 2000, 10, 100}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 4000, 20, 200}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 6000, 30, 300}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 8000, 40, 400}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 8000, 40, 500}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 8000, 40, 600}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 8000, 40, 700}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 8000, 40, 800}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 8000, 40, 900}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 8000, 40, 1000}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{2, 1, 8000, 40, 1100}, 0, '0},
        '{ROW_CONFIG, CFG_MODE, 1, '0, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{0, 1, 1000, 0, 10}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{0, 1, 2000, 0, 20}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{0, 1, 3000, 0, 30}, 0, '0},
        '{ROW_SAMPLE, CFG_THRESHOLD, 0, '{0, 1, 4000, 0, 40}, 0, '0}
    };

    // Counter delta with the wrap rule of the block: a wrapped counter
    // gives one less than the true modular difference.
    function automatic logic [31:0] count_step(input logic [31:0] cur, input logic [31:0] prev);
        return (cur >= prev) ? cur - prev : MAX32 - (prev - cur);
    endfunction

    // Rate per hundred ticks, saturated; a zero interval saturates any
    // nonzero delta.
    function automatic logic [31:0] rate_over(input logic [31:0] delta, input logic [31:0] span);
        logic [63:0] q;
        if (span == 0)
            return (delta != 0) ? MAX32 : 32'd0;
        q = 64'(delta) * 64'd100 / 64'(span);
        return (q > 64'(MAX32)) ? MAX32 : q[31:0];
    endfunction

    // Works out the result of one sample and advances the port's state.
    function automatic result_t predict_storm_result(input sample_t s);
        result_t     r;
        logic [31:0] span;
        int          p;
        p = s.port_index;
        r = '0;
        r.out_port = s.port_index;
        r.action = ACT_NONE;
        // A down port forgets its history but keeps its storm flags.
        if (!s.port_up)
        begin
            seen_rx[p] = '0;
            seen_tx[p] = '0;
            seen_tick[p] = '0;
            return r;
        end
        // Equal ticks count as a full wrap rather than a zero interval.
        span = (s.now_tick > seen_tick[p]) ? s.now_tick - seen_tick[p]
                                           : MAX32 - (seen_tick[p] - s.now_tick);
        r.rx_rate = rate_over(count_step(s.rx_bcast_count, seen_rx[p]), span);
        r.tx_rate = rate_over(count_step(s.tx_bcast_count, seen_tx[p]), span);
        seen_rx[p] = s.rx_bcast_count;
        seen_tx[p] = s.tx_bcast_count;
        seen_tick[p] = s.now_tick;

        if (r.rx_rate > storm_thresh)
        begin
            over_run[p] = over_run[p] + 3'd1;
            under_run[p] = '0;
            quiet_run[p] = '0;
        end
        else
        begin
            over_run[p] = '0;
            quiet_run[p] = quiet_pending[p] ? quiet_run[p] + 2'd1 : 2'd0;
            // The under count is left as it is after a removal; only the
            // next sample over the threshold clears it.
            if (rate_limited[p])
            begin
                under_run[p] = under_run[p] + 3'd1;
                if (under_run[p] > UNDER_LIMIT)
                begin
                    r.action = ACT_UNLIMIT;
                    quiet_pending[p] = 1'b1;
                    quiet_run[p] = '0;
                    rate_limited[p] = 1'b0;
                end
            end
        end
        // In shutdown mode every fourth storm sample in a row shuts again.
        if (over_run[p] > OVER_LIMIT)
        begin
            if (shut_on_storm)
                r.action = ACT_SHUT;
            else if (!rate_limited[p])
            begin
                r.action = ACT_LIMIT;
                rate_limited[p] = 1'b1;
            end
            over_run[p] = '0;
        end
        if (quiet_run[p] > QUIET_LIMIT)
        begin
            r.action = ACT_ALARM;
            quiet_pending[p] = 1'b0;
            quiet_run[p] = '0;
        end
        return r;
    endfunction

    // Offers one sample item, with a random gap before it, and records the
    // expected result once the block has taken it. The valid line is left
    // high after the handshake so that back-to-back items need no second
    // assignment in the same step.
    task automatic offer_sample(input sample_t s, input logic typed, input result_t want);
        result_t predicted;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.payload <= s;
        do @(posedge clk); while (!sample_ch.ready);
        predicted = predict_storm_result(s);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Stops offering items and waits until every expected result has come
    // back and the block has had time to finish its closing write.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_THRESHOLD)
            storm_thresh = value;
        else
            shut_on_storm = value[0];
        @(posedge clk);
    endtask

    // Result receiver: random back-pressure, or a long counted hold-off when
    // the stimulus asks for one.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_given)
        begin
            hold_given <= hold_asked;
            hold_left <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compares every accepted result item with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with none expected: port %0d action %0d",
                         $time, result_ch.payload.out_port, result_ch.payload.action);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.payload.out_port !== want.out_port)
                begin
                    $display("%0t: out_port expected %0d, got %0d",
                             $time, want.out_port, result_ch.payload.out_port);
                    errors++;
                end
                if (result_ch.payload.action !== want.action)
                begin
                    $display("%0t: action expected %0d, got %0d",
                             $time, want.action, result_ch.payload.action);
                    errors++;
                end
                if (result_ch.payload.rx_rate !== want.rx_rate)
                begin
                    $display("%0t: rx_rate expected %h, got %h",
                             $time, want.rx_rate, result_ch.payload.rx_rate);
                    errors++;
                end
                if (result_ch.payload.tx_rate !== want.tx_rate)
                begin
                    $display("%0t: tx_rate expected %h, got %h",
                             $time, want.tx_rate, result_ch.payload.tx_rate);
                    errors++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int                 phase;
        int                 k;
        int                 row;
        int                 pick;
        int                 p;
        sample_t            s;
        longint unsigned    iv;
        longint unsigned    target;
        longint unsigned    step;

        // Every input is known from time zero, while reset is held low.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.payload = '0;
        result_ch.ready = 1'b0;

        storm_thresh = THRESHOLD_RESET;
        shut_on_storm = 1'b0;
        for (k = 0; k < 4; k++)
        begin
            seen_rx[k] = '0;
            seen_tx[k] = '0;
            seen_tick[k] = '0;
            over_run[k] = '0;
            under_run[k] = '0;
            quiet_run[k] = '0;
            quiet_pending[k] = 1'b0;
            rate_limited[k] = 1'b0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset values of both registers until
        // the table itself changes the mode.
        for (row = 0; row < PLAN_ROWS; row++)
        begin
            if (directed_plan[row].kind == ROW_CONFIG)
            begin
                drain_results();
                write_register(directed_plan[row].reg_index, directed_plan[row].reg_value);
            end
            else
            begin
                offer_sample(directed_plan[row].smp, directed_plan[row].typed,
                             directed_plan[row].want);
            end
        end

        // Random part. Each phase sets both registers while the block is
        // idle; the thresholds include zero, one and the largest value.
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    write_register(CFG_THRESHOLD, THRESHOLD_RESET);
                    write_register(CFG_MODE, 1'b0);
                end
                1:
                begin
                    write_register(CFG_THRESHOLD, 32'd0);
                    write_register(CFG_MODE, 1'b1);
                end
                2:
                begin
                    write_register(CFG_THRESHOLD, MAX32);
                    write_register(CFG_MODE, 1'b0);
                end
                3:
                begin
                    write_register(CFG_THRESHOLD, 32'($urandom_range(1, 50000)));
                    write_register(CFG_MODE, 1'b1);
                end
                4:
                begin
                    write_register(CFG_THRESHOLD, 32'd1);
                    write_register(CFG_MODE, 1'b0);
                end
                default:
                begin
                    write_register(CFG_THRESHOLD, $urandom);
                    write_register(CFG_MODE, 1'($urandom_range(1)));
                end
            endcase

            // Sender idles lightly while the receiver stalls heavily, then
            // the reverse, then neither idles at all.
            if (phase < 2)
            begin
                tx_idle_pct = 16;
                rx_idle_pct <= 87;
            end
            else if (phase < 4)
            begin
                tx_idle_pct = 87;
                rx_idle_pct <= 16;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // The receiver holds off for a long stretch while samples
                // keep coming, so the block fills and stalls its input.
                if (phase == 0 && k == 40)
                    hold_asked <= hold_asked + 1;
                // Here the sender stops until every result has come back.
                if (phase == 3 && k == 60)
                    drain_results();

                p = $urandom_range(3);
                pick = $urandom_range(99);
                s.port_index = p[1:0];
                if (pick < 12)
                begin
                    // Noise: arbitrary counters and tick, up or down.
                    s.port_up = 1'($urandom);
                    s.rx_bcast_count = $urandom;
                    s.tx_bcast_count = $urandom;
                    s.now_tick = $urandom;
                end
                else if (pick < 17)
                begin
                    s.port_up = 1'b0;
                    s.rx_bcast_count = $urandom;
                    s.tx_bcast_count = $urandom;
                    s.now_tick = $urandom;
                end
                else
                begin
                    // Well-formed poll: the tick and counters move on from
                    // the port's last sample, with the receive delta chosen
                    // to land over or under the threshold for the whole run.
                    if (run_left[p] == 0)
                    begin
                        run_storm[p] = 1'($urandom_range(1));
                        run_left[p] = run_storm[p] ? $urandom_range(2, 6) : $urandom_range(1, 9);
                    end
                    run_left[p]--;
                    iv = $urandom_range(1, 2000);
                    if (run_storm[p])
                    begin
                        target = 64'(storm_thresh) + 1 + $urandom_range(0, 500);
                        step = (target * iv + 99) / 100;
                    end
                    else
                    begin
                        target = 64'($urandom) % (64'(storm_thresh) + 1);
                        step = target * iv / 100;
                    end
                    if (step > 64'hFFFF_FFFE)
                        step = 64'hFFFF_FFFE;
                    s.port_up = 1'b1;
                    s.rx_bcast_count = seen_rx[p] + step[31:0];
                    s.tx_bcast_count = seen_tx[p] + 32'($urandom_range(0, 5000));
                    s.now_tick = seen_tick[p] + iv[31:0];
                end
                offer_sample(s, 1'b0, '0);
            end
        end

        drain_results();
        if (errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
